FILE: sv/bb_pkg.sv
// shared constants and types of the 6x6 box blur
// no dependencies
`default_nettype none
package bb_pkg;

  localparam int DEF_RADIUS    = 3;
  localparam int DEF_MAX_WIDTH = 2048;

  localparam int PIX_W = 8;
  localparam int NCH   = 4;
  localparam int WORD_W = PIX_W * NCH;

  localparam int W_CFG      = 12;
  localparam int H_CFG      = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  localparam logic [W_CFG-1:0] RESET_WIDTH  = 12'd640;
  localparam logic [H_CFG-1:0] RESET_HEIGHT = 13'd480;

  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 8;

  typedef struct packed {
    logic clear;
    logic emit;
    logic last;
  } bb_flags_t;

endpackage
`default_nettype wire

FILE: sv/bb_ram.sv
// generic single write port ram with registered read
// no dependencies
`default_nettype none
module bb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

FILE: sv/bb_fifo.sv
// small register based fifo, first word shown on rdata_o
// no dependencies
`default_nettype none
module bb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire logic [WIDTH-1:0]           wdata_i,
  input  wire logic                       pop_i,
  output logic      [WIDTH-1:0]           rdata_o,
  output logic                            empty_o,
  output logic      [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;
  logic             do_pop;

  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign rdata_o = mem_q[rd_q];
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

FILE: sv/bb_front.sv
// front end: frame position counters, line stores and column sums
// depends on bb_pkg and bb_ram
`default_nettype none
module bb_front #(
  parameter int RADIUS    = bb_pkg::DEF_RADIUS,
  parameter int MAX_WIDTH = bb_pkg::DEF_MAX_WIDTH
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [bb_pkg::W_CFG-1:0]  width_i,
  input  wire logic [bb_pkg::H_CFG-1:0]  height_i,
  input  wire logic                      restart_i,
  input  wire logic                      take_i,
  input  wire logic [bb_pkg::PIX_W-1:0]  red_i,
  input  wire logic [bb_pkg::PIX_W-1:0]  green_i,
  input  wire logic [bb_pkg::PIX_W-1:0]  blue_i,
  input  wire logic [bb_pkg::PIX_W-1:0]  alpha_i,
  output logic                           col_valid_o,
  output logic [bb_pkg::NCH*(bb_pkg::PIX_W+$clog2(2*RADIUS))-1:0] col_sum_o,
  output bb_pkg::bb_flags_t              col_flags_o
);
  import bb_pkg::*;

  localparam int WIN   = 2 * RADIUS;
  localparam int LINES = 2 * RADIUS - 1;
  localparam int LOOK  = RADIUS - 1;
  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int CW    = $clog2(MAX_WIDTH + WIN);
  localparam int RW    = H_CFG + 1;
  localparam int LW    = $clog2(LINES + 1);
  localparam int COL_W = PIX_W + $clog2(WIN);

  logic [CW-1:0]  c_q, c_d, w, cols;
  logic [RW-1:0]  r_q, r_d, h, rows;
  logic [LW-1:0]  line_q, line_d;
  logic           col_in, in_img, last_col, last_row, emit;
  logic [WORD_W-1:0] pix;
  logic [LW-1:0]  rows_back [LINES];
  logic [LINES-1:0] mask;

  logic              v_q;
  logic [WORD_W-1:0] pix_q;
  logic [LINES-1:0]  mask_q;
  bb_flags_t         flags_q;
  logic [WORD_W-1:0] ram_rd [LINES];

  assign w    = (int'(width_i) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(width_i);
  assign cols = w + CW'(LOOK);
  assign h    = RW'(height_i);
  assign rows = h + RW'(LOOK);

  assign col_in   = (c_q < w);
  assign in_img   = col_in && (r_q < h);
  assign last_col = ({1'b0, c_q} + 1'b1) >= {1'b0, cols};
  assign last_row = ({1'b0, r_q} + 1'b1) >= {1'b0, rows};
  assign emit     = (c_q >= CW'(LOOK)) && (r_q >= RW'(LOOK)) &&
                    ((c_q - CW'(LOOK)) < w) && ((r_q - RW'(LOOK)) < h);
  assign pix      = in_img ? {alpha_i, blue_i, green_i, red_i} : '0;

  // store i holds rows whose index mod LINES is i, distance back from r
  always_comb begin
    for (int i = 0; i < LINES; i++) begin
      if (line_q >= LW'(i)) begin
        rows_back[i] = line_q - LW'(i);
      end else begin
        rows_back[i] = LW'(LINES - i) + line_q;
      end
      if (rows_back[i] == '0) begin
        rows_back[i] = LW'(LINES);
      end
      mask[i] = col_in && (r_q >= RW'(rows_back[i]));
    end
  end

  for (genvar gi = 0; gi < LINES; gi++) begin : g_line
    bb_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_WIDTH)
    ) u_line (
      .clk_i   (clk_i),
      .we_i    (take_i && col_in && (line_q == LW'(gi))),
      .waddr_i (c_q[AW-1:0]),
      .wdata_i (pix),
      .raddr_i (c_q[AW-1:0]),
      .rdata_o (ram_rd[gi])
    );
  end

  always_comb begin
    c_d    = c_q;
    r_d    = r_q;
    line_d = line_q;
    if (restart_i) begin
      c_d    = '0;
      r_d    = '0;
      line_d = '0;
    end else if (take_i) begin
      if (last_col) begin
        c_d = '0;
        if (last_row) begin
          r_d    = '0;
          line_d = '0;
        end else begin
          r_d    = r_q + 1'b1;
          line_d = (line_q == LW'(LINES - 1)) ? '0 : line_q + 1'b1;
        end
      end else begin
        c_d = c_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q    <= '0;
      r_q    <= '0;
      line_q <= '0;
      v_q    <= 1'b0;
    end else begin
      c_q    <= c_d;
      r_q    <= r_d;
      line_q <= line_d;
      v_q    <= take_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      pix_q         <= pix;
      mask_q        <= mask;
      flags_q.clear <= (c_q == '0);
      flags_q.emit  <= emit;
      flags_q.last  <= last_col && last_row;
    end
  end

  // column sum: current pixel plus the valid rows above it
  always_comb begin
    logic [COL_W-1:0] acc;
    for (int ch = 0; ch < NCH; ch++) begin
      acc = COL_W'(pix_q[ch*PIX_W +: PIX_W]);
      for (int i = 0; i < LINES; i++) begin
        if (mask_q[i]) begin
          acc = acc + COL_W'(ram_rd[i][ch*PIX_W +: PIX_W]);
        end
      end
      col_sum_o[ch*COL_W +: COL_W] = acc;
    end
  end

  assign col_valid_o = v_q;
  assign col_flags_o = flags_q;

endmodule
`default_nettype wire

FILE: sv/bb_back.sv
// back end: window of column sums, total, division by the window area, result queue
// depends on bb_pkg and bb_fifo
`default_nettype none
module bb_back #(
  parameter int RADIUS = bb_pkg::DEF_RADIUS
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     mid_empty_i,
  input  wire logic [bb_pkg::NCH*(bb_pkg::PIX_W+$clog2(2*RADIUS))-1:0] mid_sum_i,
  input  wire bb_pkg::bb_flags_t        mid_flags_i,
  output logic                          mid_pop_o,
  input  wire logic                     pop_i,
  output logic                          empty_o,
  output logic [bb_pkg::PIX_W-1:0]      red_o,
  output logic [bb_pkg::PIX_W-1:0]      green_o,
  output logic [bb_pkg::PIX_W-1:0]      blue_o,
  output logic [bb_pkg::PIX_W-1:0]      alpha_o,
  output logic                          frame_end_o
);
  import bb_pkg::*;

  localparam int WIN   = 2 * RADIUS;
  localparam int COL_W = PIX_W + $clog2(WIN);
  localparam int SUM_W = COL_W + $clog2(WIN);
  localparam int DIV   = 4 * RADIUS * RADIUS;
  localparam int K     = SUM_W + $clog2(DIV) + 1;
  localparam longint unsigned MUL = ((64'd1 << K) + 64'(DIV) - 64'd1) / 64'(DIV);
  localparam int MW    = K + 1;
  localparam int PW    = SUM_W + MW;
  localparam int OW    = NCH * PIX_W + 1;
  localparam int CNTW  = $clog2(OUT_DEPTH + 1);
  localparam int OCCW  = $clog2(OUT_DEPTH + 4);

  logic [WIN-1:0][NCH-1:0][COL_W-1:0] win_q;
  logic [NCH-1:0][SUM_W-1:0] tot_q;
  logic [NCH-1:0][PW-1:0]    prod_q;
  logic ea_q, eb_q, ec_q, la_q, lb_q, lc_q;
  logic [CNTW-1:0] out_cnt;
  logic [OCCW-1:0] occ;
  logic [OW-1:0]   out_wdata, out_rdata;

  // credit: room in the result queue for everything still in the pipe
  assign occ = OCCW'(out_cnt) + OCCW'(ea_q) + OCCW'(eb_q) + OCCW'(ec_q);
  assign mid_pop_o = !mid_empty_i && (occ < OCCW'(OUT_DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ea_q <= 1'b0;
      eb_q <= 1'b0;
      ec_q <= 1'b0;
    end else begin
      ea_q <= mid_pop_o && mid_flags_i.emit;
      eb_q <= ea_q;
      ec_q <= eb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_pop_o) begin
      for (int j = 0; j < WIN - 1; j++) begin
        win_q[j] <= mid_flags_i.clear ? '0 : win_q[j+1];
      end
      win_q[WIN-1] <= mid_sum_i;
      la_q         <= mid_flags_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [SUM_W-1:0] acc;
    for (int ch = 0; ch < NCH; ch++) begin
      acc = '0;
      for (int j = 0; j < WIN; j++) begin
        acc = acc + SUM_W'(win_q[j][ch]);
      end
      tot_q[ch] <= acc;
    end
    lb_q <= la_q;
  end

  // divide by the area as a multiply by the rounded-up reciprocal
  always_ff @(posedge clk_i) begin
    for (int ch = 0; ch < NCH; ch++) begin
      prod_q[ch] <= PW'(tot_q[ch]) * PW'(MUL);
    end
    lc_q <= lb_q;
  end

  always_comb begin
    out_wdata[OW-1] = lc_q;
    for (int ch = 0; ch < NCH; ch++) begin
      out_wdata[ch*PIX_W +: PIX_W] = prod_q[ch][K +: PIX_W];
    end
  end

  bb_fifo #(
    .WIDTH (OW),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (ec_q),
    .wdata_i (out_wdata),
    .pop_i   (pop_i),
    .rdata_o (out_rdata),
    .empty_o (empty_o),
    .count_o (out_cnt)
  );

  assign red_o       = out_rdata[0*PIX_W +: PIX_W];
  assign green_o     = out_rdata[1*PIX_W +: PIX_W];
  assign blue_o      = out_rdata[2*PIX_W +: PIX_W];
  assign alpha_o     = out_rdata[3*PIX_W +: PIX_W];
  assign frame_end_o = out_rdata[OW-1];

endmodule
`default_nettype wire

FILE: sv/box_blur_6x6_top.sv
// top level of the 6x6 box blur: config registers, front end, column queue, back end
// depends on bb_pkg, bb_front, bb_fifo and bb_back
//
// usage
// - pixels enter through a queue style port: a request is taken when push is
//   high and full is low, one per clock at most, in raster order over the
//   padded frame of (width+2) by (height+2) positions; channel values at
//   padding positions are ignored
// - results leave through a queue style port: the oldest mean is on the
//   output ports while empty is low and is taken when pop is high
// - frame_end_o marks the last result of a frame
// - a taken pixel passes the front registers, column queue, window, total, product
//   and result queue; throughput is one pixel per clock when nothing stalls, set by
//   the single pass through the line store rams (all read, one written each cycle)
// - a stalled receiver fills the result queue, then the column queue, then
//   full rises; nothing is lost
// - reset clears the frame position and sets width 640 and height 480;
//   line store contents are not cleared, rows above the image read as zero
// - a width or height write restarts the frame at its first position; the user
//   must issue it only while the block is idle, and the block does not enforce this
`default_nettype none
module box_blur_6x6_top #(
  parameter int RADIUS    = bb_pkg::DEF_RADIUS,
  parameter int MAX_WIDTH = bb_pkg::DEF_MAX_WIDTH
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [bb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [bb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [bb_pkg::PIX_W-1:0]      red_in_i,
  input  wire logic [bb_pkg::PIX_W-1:0]      green_in_i,
  input  wire logic [bb_pkg::PIX_W-1:0]      blue_in_i,
  input  wire logic [bb_pkg::PIX_W-1:0]      alpha_in_i,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [bb_pkg::PIX_W-1:0]           red_out_o,
  output logic [bb_pkg::PIX_W-1:0]           green_out_o,
  output logic [bb_pkg::PIX_W-1:0]           blue_out_o,
  output logic [bb_pkg::PIX_W-1:0]           alpha_out_o,
  output logic                               frame_end_o
);
  import bb_pkg::*;

  localparam int COL_W = PIX_W + $clog2(2 * RADIUS);
  localparam int SW    = NCH * COL_W;
  localparam int MW    = SW + $bits(bb_flags_t);
  localparam int MCW   = $clog2(MID_DEPTH + 1);

  logic [W_CFG-1:0] width_q;
  logic [H_CFG-1:0] height_q;
  logic             restart;
  logic             take;

  logic             col_valid;
  logic [SW-1:0]    col_sum, mid_sum;
  bb_flags_t        col_flags, mid_flags;
  logic [MW-1:0]    mid_rdata;
  logic             mid_empty, mid_pop;
  logic [MCW-1:0]   mid_cnt;

  // config registers, a write to either one restarts the frame
  assign restart = cfg_we_i && ((cfg_index_i == REG_WIDTH) || (cfg_index_i == REG_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RESET_WIDTH;
      height_q <= RESET_HEIGHT;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_WIDTH) begin
        width_q <= cfg_data_i[W_CFG-1:0];
      end
      if (cfg_index_i == REG_HEIGHT) begin
        height_q <= cfg_data_i[H_CFG-1:0];
      end
    end
  end

  // keep room in the column queue for the request whose ram read is pending
  assign full = ({1'b0, mid_cnt} + (MCW+1)'(col_valid)) >= (MCW+1)'(MID_DEPTH);
  assign take = push && !full;

  bb_front #(
    .RADIUS    (RADIUS),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .width_i     (width_q),
    .height_i    (height_q),
    .restart_i   (restart),
    .take_i      (take),
    .red_i       (red_in_i),
    .green_i     (green_in_i),
    .blue_i      (blue_in_i),
    .alpha_i     (alpha_in_i),
    .col_valid_o (col_valid),
    .col_sum_o   (col_sum),
    .col_flags_o (col_flags)
  );

  // column queue between front and back
  bb_fifo #(
    .WIDTH (MW),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (col_valid),
    .wdata_i ({col_flags, col_sum}),
    .pop_i   (mid_pop),
    .rdata_o (mid_rdata),
    .empty_o (mid_empty),
    .count_o (mid_cnt)
  );

  assign mid_sum   = mid_rdata[SW-1:0];
  assign mid_flags = mid_rdata[MW-1:SW];

  bb_back #(
    .RADIUS (RADIUS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_empty_i (mid_empty),
    .mid_sum_i   (mid_sum),
    .mid_flags_i (mid_flags),
    .mid_pop_o   (mid_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .red_o       (red_out_o),
    .green_o     (green_out_o),
    .blue_o      (blue_out_o),
    .alpha_o     (alpha_out_o),
    .frame_end_o (frame_end_o)
  );

endmodule
`default_nettype wire

FILE: sim/tb_top.sv
// self-checking testbench of the 6x6 box blur: directed and random frames under idling and backpressure
// depends on bb_pkg and box_blur_6x6_top
`default_nettype none

typedef struct packed {
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       last;
} blur_mean_t;

class blur_scoreboard;
  logic [31:0] line_mem [5][2048];
  logic [31:0] win [6][6];
  int unsigned col, row, img_w, img_h;
  blur_mean_t  means_q [$];
  int          errors;

  function new();
    col = 0; row = 0; img_w = 640; img_h = 480; errors = 0;
    foreach (win[k, j]) win[k][j] = '0;
  endfunction

  function void set_reg(logic [bb_pkg::CFG_IDX_W-1:0] idx, logic [12:0] val);
    if (idx == bb_pkg::REG_WIDTH) img_w = 32'(val[11:0]);
    else img_h = 32'(val[12:0]);
    col = 0;
    row = 0;
  endfunction

  // one accepted pixel: advance the window and predict a mean if one is due
  function void note_pixel(logic [31:0] px_in);
    int unsigned w, h, d, sum;
    logic [31:0] px, v;
    blur_mean_t m;
    bit last_col, last_row;
    w = (img_w > 2048) ? 2048 : img_w;
    h = img_h;
    px = '0;
    if (col == 0) foreach (win[k, j]) win[k][j] = '0;
    if (col < w && row < h) px = px_in;
    for (int k = 0; k < 6; k++)
      for (int j = 0; j < 5; j++) win[k][j] = win[k][j+1];
    for (int k = 0; k < 5; k++) begin
      d = 5 - k;
      v = '0;
      if (col < w && row >= d) v = line_mem[(row - d) % 5][col];
      win[k][5] = v;
    end
    win[5][5] = px;
    if (col < w) line_mem[row % 5][col] = px;
    last_col = (col + 1 >= w + 2);
    last_row = (row + 1 >= h + 2);
    if (col >= 2 && row >= 2 && col - 2 < w && row - 2 < h) begin
      for (int ch = 0; ch < 4; ch++) begin
        sum = 0;
        foreach (win[k, j]) sum += (win[k][j] >> (8 * ch)) & 8'hff;
        case (ch)
          0: m.red   = 8'(sum / 36);
          1: m.green = 8'(sum / 36);
          2: m.blue  = 8'(sum / 36);
          default: m.alpha = 8'(sum / 36);
        endcase
      end
      m.last = last_col && last_row;
      means_q.push_back(m);
    end
    if (last_col) begin
      col = 0;
      row = last_row ? 0 : row + 1;
    end else begin
      col = col + 1;
    end
  endfunction

  function void check_mean(blur_mean_t got);
    blur_mean_t exp_m;
    if (means_q.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    exp_m = means_q.pop_front();
    if (got.red !== exp_m.red)
      $display("%0t: red exp %0d got %0d", $time, exp_m.red, got.red);
    if (got.green !== exp_m.green)
      $display("%0t: green exp %0d got %0d", $time, exp_m.green, got.green);
    if (got.blue !== exp_m.blue)
      $display("%0t: blue exp %0d got %0d", $time, exp_m.blue, got.blue);
    if (got.alpha !== exp_m.alpha)
      $display("%0t: alpha exp %0d got %0d", $time, exp_m.alpha, got.alpha);
    if (got.last !== exp_m.last)
      $display("%0t: frame_end exp %0b got %0b", $time, exp_m.last, got.last);
    if (got !== exp_m) errors++;
  endfunction
endclass

module tb_top;
  import bb_pkg::*;

  localparam int DRAIN_CYCLES = 20;    // settle time after the last expected mean
  localparam int STUCK_LIMIT  = 5000;  // cycles with no request moving either way
  localparam int ITEMS        = 1450;  // pixel requests after which the random frames stop

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = REG_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  push = 1'b0;
  logic                  full;
  logic [7:0]            red_in_i = '0, green_in_i = '0, blue_in_i = '0, alpha_in_i = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [7:0]            red_out_o, green_out_o, blue_out_o, alpha_out_o;
  logic                  frame_end_o;

  blur_scoreboard sb = new();
  int send_idle_pct  = 0;   // sender idle chance per request
  int recv_stall_pct = 0;   // receiver stall chance per cycle
  int hold_left      = 0;   // long receiver hold-off, counted down by the receiver
  int stuck_cycles   = 0;
  int sent_items     = 0;

  always #6 clk_i = ~clk_i;

  box_blur_6x6_top i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .push, .full, .red_in_i, .green_in_i, .blue_in_i, .alpha_in_i,
    .empty, .pop, .red_out_o, .green_out_o, .blue_out_o, .alpha_out_o, .frame_end_o
  );

  // input side monitor: every accepted pixel request feeds the predictor
  always @(posedge clk_i) begin
    if (rst_ni && push && !full)
      sb.note_pixel({alpha_in_i, blue_in_i, green_in_i, red_in_i});
  end

  // result side monitor
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty)
      sb.check_mean('{red_out_o, green_out_o, blue_out_o, alpha_out_o, frame_end_o});
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      pop = 1'b0;
      hold_left--;
    end else begin
      pop = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog: ends the run if nothing moves for too long
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // register write, only while the block is idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [12:0] val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // wait for every expected mean, then let a frame tail with no results settle
  task automatic drain();
    while (sb.means_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_channel();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  // one pixel request, held until taken; fill 1 sends all ones, 2 all zeros
  task automatic send_pixel(int fill);
    if ($urandom_range(99) < send_idle_pct) begin
      push = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
    push       = 1'b1;
    red_in_i   = (fill == 1) ? 8'hff : (fill == 2) ? 8'h00 : pick_channel();
    green_in_i = (fill == 1) ? 8'hff : (fill == 2) ? 8'h00 : pick_channel();
    blue_in_i  = (fill == 1) ? 8'hff : (fill == 2) ? 8'h00 : pick_channel();
    alpha_in_i = (fill == 1) ? 8'hff : (fill == 2) ? 8'h00 : pick_channel();
    do @(posedge clk_i); while (full);
    sent_items++;
    @(negedge clk_i);
  endtask

  // configure, then stream count pixel requests (a whole padded frame when count < 0)
  task automatic run_frame(int w, int h, int fill, int count = -1);
    int n;
    write_reg(REG_WIDTH, 13'(w));
    write_reg(REG_HEIGHT, 13'(h));
    n = (count < 0) ? ((w > 2048 ? 2048 : w) + 2) * (h + 2) : count;
    for (int i = 0; i < n; i++) send_pixel(fill);
    push = 1'b0;
    drain();
  endtask

  initial begin
    int w, h;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: smallest image in all ones and all zeros, then mixed extremes
    run_frame(1, 1, 1);
    run_frame(1, 1, 2);
    run_frame(6, 5, 1);
    run_frame(7, 6, 0);
    // zero width and zero height walk the padding only
    run_frame(0, 3, 0);
    run_frame(4, 0, 0);
    // frame cut short, then a register write restarts it
    run_frame(9, 7, 0, 40);
    run_frame(3, 2, 0);
    // widest settings and tallest image, cut short after the first pixels
    run_frame(4095, 1, 0, 150);
    run_frame(2048, 1, 0, 150);
    run_frame(1, 4096, 0, 60);
    run_frame(2, 8191, 2, 60);
    run_frame(5, 4, 0);

    // random frames, idling phase rotating per frame
    for (int f = 0; sent_items < ITEMS; f++) begin
      case (f % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      w = $urandom_range(20, 1);
      h = $urandom_range(12, 1);
      if (f == 2) begin
        // long receiver hold-off so the block fills and stalls its input
        w = 20;
        h = 10;
        hold_left = 400;
      end
      run_frame(w, h, 0);
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.means_q.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule

`default_nettype wire

FILE: sim.f
sv/bb_pkg.sv
sv/bb_ram.sv
sv/bb_fifo.sv
sv/bb_front.sv
sv/bb_back.sv
sv/box_blur_6x6_top.sv
sim/tb_top.sv
